// ===== hdl/dtq_pkg.sv =====
// Shared types, codes and constants of the deadline timer queue.
// Used by dtq_controller, dtq_datapath, deadline_timer_queue and tb_top; depends on nothing.

package dtq_pkg;

    // Sizes of the timer table and of the fields.
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W          = 48;
    localparam int ID_W            = 32;

    // Input item kinds.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_ABS    = 2'd1;
    localparam logic [1:0] KIND_REL    = 2'd2;
    localparam logic [1:0] KIND_CANCEL = 2'd3;

    // Result kinds.
    localparam logic [2:0] RK_CREATED   = 3'd0;
    localparam logic [2:0] RK_FIRED     = 3'd1;
    localparam logic [2:0] RK_CANCELLED = 3'd2;
    localparam logic [2:0] RK_NOT_FOUND = 3'd3;
    localparam logic [2:0] RK_FULL      = 3'd4;

    // One input transaction.
    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] time_value;
        logic [ID_W-1:0]   cancel_id;
    } dtq_in_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]      result_kind;
        logic [ID_W-1:0] tmr_id;
        logic            is_last;
    } dtq_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } dtq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rescan;
        logic scan;
        logic decide;
        logic out_ack;
    } dtq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic emit;
        logic rescan;
        logic more;
    } dtq_stat_t;

endpackage

// ===== hdl/dtq_controller.sv =====
// Sequencing state machine of the deadline timer queue.
// Depends on dtq_pkg; drives dtq_datapath through command and status structs.

module dtq_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                result_stall,
    input  dtq_pkg::dtq_stat_t  stat,
    output dtq_pkg::dtq_cmd_t   cmd
);

    dtq_pkg::dtq_state_t state_reg;
    dtq_pkg::dtq_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = dtq_pkg::ST_SCAN;
                end
            end
            dtq_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = dtq_pkg::ST_DECIDE;
                end
            end
            dtq_pkg::ST_DECIDE:
            begin
                if (stat.emit)
                begin
                    state_next = dtq_pkg::ST_OUT;
                end
                else if (stat.rescan)
                begin
                    state_next = dtq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            dtq_pkg::ST_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = stat.more ? dtq_pkg::ST_SCAN : dtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and the input stall.
    always_comb
    begin
        item_stall  = 1'b1;
        cmd         = '0;
        case (state_reg)
            dtq_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            dtq_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            dtq_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                cmd.rescan = !stat.emit && stat.rescan;
            end
            dtq_pkg::ST_OUT:
            begin
                cmd.out_ack = !result_stall;
                cmd.rescan  = !result_stall && stat.more;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/dtq_datapath.sv =====
// Timer table, scan pipeline, best-entry tracking and result register.
// Depends on dtq_pkg; controlled by dtq_controller.

module dtq_datapath #(
    parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::dtq_in_t    item,
    input  dtq_pkg::dtq_cmd_t   cmd,
    output dtq_pkg::dtq_stat_t  stat,
    output logic                result_valid,
    output dtq_pkg::dtq_out_t   result
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam int TW = dtq_pkg::TIME_W;
    localparam int IW = dtq_pkg::ID_W;
    localparam int CW = dtq_pkg::CNT_W;

    // Table storage: valid bits in flops, deadlines and ids in memories.
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TW-1:0]          dl_mem [TABLE_DEPTH];
    logic [IW-1:0]          id_mem [TABLE_DEPTH];

    // Persistent state.
    logic [TW-1:0] now_reg, now_next;
    logic [IW-1:0] next_id_reg, next_id_next;

    // Current transaction.
    logic [1:0]    kind_reg, kind_next;
    logic [TW-1:0] time_reg, time_next;
    logic [IW-1:0] cid_reg, cid_next;

    // Scan read stage.
    logic             issue_reg, issue_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             rd_live_reg, rd_live_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_slot_reg, rd_slot_next;
    logic [TW-1:0]    rd_dl_reg;
    logic [IW-1:0]    rd_id_reg;

    // Best entry found so far in this scan.
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_slot_reg, best_slot_next;
    logic [TW-1:0]    best_dl_reg, best_dl_next;
    logic [IW-1:0]    best_id_reg, best_id_next;
    logic [IW-1:0]    best_age_reg, best_age_next;

    // Fired timer waiting until it is known whether it is the last one.
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_id_reg, pend_id_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Result register.
    logic              result_valid_reg, result_valid_next;
    dtq_pkg::dtq_out_t result_reg, result_next;

    logic [TW:0]   rel_sum;
    logic [IW-1:0] rd_age;
    logic [IW-1:0] id_inc;
    logic          is_tick;
    logic          is_cancel;
    logic          cand;
    logic          better;
    logic          take;
    logic          found_eff;

    // Entry evaluation and decision flags.
    always_comb
    begin
        is_tick   = (kind_reg == dtq_pkg::KIND_TICK);
        is_cancel = (kind_reg == dtq_pkg::KIND_CANCEL);
        rd_age    = next_id_reg - rd_id_reg;
        if (is_tick)
        begin
            cand = rd_vld_reg && (rd_dl_reg <= now_reg);
        end
        else if (is_cancel)
        begin
            cand = rd_vld_reg && (rd_id_reg == cid_reg);
        end
        else
        begin
            cand = !rd_vld_reg;
        end
        // Ticks keep the earliest deadline, older timer on a tie; others keep the lowest slot.
        better = !best_found_reg
              || (is_tick && ((rd_dl_reg < best_dl_reg)
                              || ((rd_dl_reg == best_dl_reg) && (rd_age > best_age_reg))));
        take      = rd_live_reg && cand && better;
        found_eff = best_found_reg && (!is_tick || (cnt_reg < CW'(dtq_pkg::MAX_RESULTS)));
        rel_sum   = {1'b0, now_reg} + {1'b0, item.time_value};
        id_inc    = next_id_reg + IW'(1);
    end

    assign stat.scan_done = rd_live_reg && (rd_slot_reg == LAST_IDX);
    assign stat.emit      = !is_tick || pend_reg;
    assign stat.rescan    = is_tick && found_eff;
    assign stat.more      = pend_reg;

    // Next-state logic of the whole datapath.
    always_comb
    begin
        valid_next        = valid_reg;
        now_next          = now_reg;
        next_id_next      = next_id_reg;
        kind_next         = kind_reg;
        time_next         = time_reg;
        cid_next          = cid_reg;
        issue_next        = issue_reg;
        idx_next          = idx_reg;
        rd_live_next      = 1'b0;
        rd_vld_next       = rd_vld_reg;
        rd_slot_next      = rd_slot_reg;
        best_found_next   = best_found_reg;
        best_slot_next    = best_slot_reg;
        best_dl_next      = best_dl_reg;
        best_id_next      = best_id_reg;
        best_age_next     = best_age_reg;
        pend_next         = pend_reg;
        pend_id_next      = pend_id_reg;
        cnt_next          = cnt_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        // Capture a new transaction; relative deadlines saturate.
        if (cmd.load)
        begin
            kind_next = item.kind;
            cid_next  = item.cancel_id;
            pend_next = 1'b0;
            cnt_next  = '0;
            if (item.kind == dtq_pkg::KIND_REL)
            begin
                time_next = rel_sum[TW] ? {TW{1'b1}} : rel_sum[TW-1:0];
            end
            else
            begin
                time_next = item.time_value;
            end
            if (item.kind == dtq_pkg::KIND_TICK)
            begin
                now_next = item.time_value;
            end
        end

        // Start a scan from slot zero.
        if (cmd.load || cmd.rescan)
        begin
            issue_next      = 1'b1;
            idx_next        = '0;
            best_found_next = 1'b0;
        end

        // Scan: read one slot per cycle, evaluate it the cycle after.
        if (cmd.scan)
        begin
            if (issue_reg)
            begin
                rd_live_next = 1'b1;
                rd_slot_next = idx_reg;
                rd_vld_next  = valid_reg[idx_reg];
                idx_next     = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    issue_next = 1'b0;
                end
            end
            if (take)
            begin
                best_found_next = 1'b1;
                best_slot_next  = rd_slot_reg;
                best_dl_next    = rd_dl_reg;
                best_id_next    = rd_id_reg;
                best_age_next   = rd_age;
            end
        end

        // Act on the scan outcome.
        if (cmd.decide)
        begin
            result_next.is_last = 1'b1;
            case (kind_reg)
                dtq_pkg::KIND_TICK:
                begin
                    result_next.result_kind = dtq_pkg::RK_FIRED;
                    result_next.tmr_id      = pend_id_reg;
                    result_next.is_last     = !found_eff;
                    result_valid_next       = pend_reg;
                    pend_next               = found_eff;
                    if (found_eff)
                    begin
                        valid_next[best_slot_reg] = 1'b0;
                        pend_id_next              = best_id_reg;
                        cnt_next                  = cnt_reg + CW'(1);
                    end
                end
                dtq_pkg::KIND_CANCEL:
                begin
                    result_valid_next = 1'b1;
                    if (best_found_reg)
                    begin
                        valid_next[best_slot_reg] = 1'b0;
                        result_next.result_kind   = dtq_pkg::RK_CANCELLED;
                        result_next.tmr_id        = best_id_reg;
                    end
                    else
                    begin
                        result_next.result_kind = dtq_pkg::RK_NOT_FOUND;
                        result_next.tmr_id      = '0;
                    end
                end
                default:
                begin
                    result_valid_next = 1'b1;
                    if (best_found_reg)
                    begin
                        valid_next[best_slot_reg] = 1'b1;
                        result_next.result_kind   = dtq_pkg::RK_CREATED;
                        result_next.tmr_id        = next_id_reg;
                        // Ids count up and skip zero.
                        next_id_next = (id_inc == '0) ? IW'(1) : id_inc;
                    end
                    else
                    begin
                        result_next.result_kind = dtq_pkg::RK_FULL;
                        result_next.tmr_id      = '0;
                    end
                end
            endcase
        end

        // Result taken by the receiver.
        if (cmd.out_ack)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            now_reg          <= '0;
            next_id_reg      <= IW'(1);
            issue_reg        <= 1'b0;
            idx_reg          <= '0;
            rd_live_reg      <= 1'b0;
            best_found_reg   <= 1'b0;
            pend_reg         <= 1'b0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
            kind_reg         <= dtq_pkg::KIND_TICK;
        end
        else
        begin
            valid_reg        <= valid_next;
            now_reg          <= now_next;
            next_id_reg      <= next_id_next;
            issue_reg        <= issue_next;
            idx_reg          <= idx_next;
            rd_live_reg      <= rd_live_next;
            best_found_reg   <= best_found_next;
            pend_reg         <= pend_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
            kind_reg         <= kind_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        time_reg      <= time_next;
        cid_reg       <= cid_next;
        rd_vld_reg    <= rd_vld_next;
        rd_slot_reg   <= rd_slot_next;
        best_slot_reg <= best_slot_next;
        best_dl_reg   <= best_dl_next;
        best_id_reg   <= best_id_next;
        best_age_reg  <= best_age_next;
        pend_id_reg   <= pend_id_next;
        result_reg    <= result_next;
    end

    // Deadline and id memories: written on create, read by the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.decide && (kind_reg inside {dtq_pkg::KIND_ABS, dtq_pkg::KIND_REL})
            && best_found_reg)
        begin
            dl_mem[best_slot_reg] <= time_reg;
            id_mem[best_slot_reg] <= next_id_reg;
        end
        if (cmd.scan && issue_reg)
        begin
            rd_dl_reg <= dl_mem[idx_reg];
            rd_id_reg <= id_mem[idx_reg];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: controller plus datapath.
// Depends on dtq_pkg, dtq_controller and dtq_datapath.

// The block holds up to TABLE_DEPTH pending one-shot timers and handles one
// transaction at a time: it stalls its input from acceptance until the last
// result of that transaction has been taken. Every operation walks the timer
// table one slot per cycle through a single memory read port. A create or
// cancel delivers its single result after one scan; a tick that fires n
// timers runs n + 1 scans and fires at most 16 timers, leaving the rest due
// for the next tick. A tick with nothing due produces no result and frees
// the input after one scan. Results of one transaction end with is_last set.

module deadline_timer_queue #(
    parameter int TABLE_DEPTH = dtq_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  dtq_pkg::dtq_in_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output dtq_pkg::dtq_out_t  result
);

    dtq_pkg::dtq_cmd_t  cmd;
    dtq_pkg::dtq_stat_t stat;

    // Sequencer.
    dtq_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Timer table and result path.
    dtq_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for deadline_timer_queue: directed and random timer traffic.
// Depends on dtq_pkg and the deadline_timer_queue RTL; the expected results come from
// a behavioral timer table kept inside this file.
`timescale 1ns / 100ps

module tb_top;

    localparam int          TW          = dtq_pkg::TIME_W;
    localparam int          IW          = dtq_pkg::ID_W;
    localparam int          TQ_DEPTH    = dtq_pkg::TABLE_DEPTH_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          RANDOM_OPS  = 140;
    localparam logic [TW-1:0] MAX_MS    = {TW{1'b1}};

    // Clock, reset and the block's ports.
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    dtq_pkg::dtq_in_t  item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    dtq_pkg::dtq_out_t result;

    // Behavioral copy of the timer table.
    logic          slot_used [TQ_DEPTH];
    logic [TW-1:0] slot_due  [TQ_DEPTH];
    logic [IW-1:0] slot_tid  [TQ_DEPTH];
    logic [TW-1:0] now_ms     = '0;
    logic [IW-1:0] id_counter = IW'(1);

    // Transactions waiting to be sent and results still to arrive.
    dtq_pkg::dtq_in_t  timer_ops_q [$];
    dtq_pkg::dtq_out_t due_results [$];
    dtq_pkg::dtq_out_t want;

    // Bookkeeping shared between the driver, the monitor and the sequencer.
    int  sent_cnt      = 0;
    int  taken_cnt     = 0;
    int  gap_left      = 0;
    int  results_seen  = 0;
    int  results_paced = 0;
    int  stall_left    = 0;
    int  error_count   = 0;
    int  cycle_count   = 0;
    int  random_ops    = 0;
    int  fired_seen    = 0;
    int  full_seen     = 0;
    int  cancel_hits   = 0;
    int  miss_seen     = 0;
    bit  tx_quiet      = 1'b0;
    bit  rx_quiet      = 1'b0;

    deadline_timer_queue u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < TQ_DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
        end
    end

    // Work out the results of one accepted transaction and update the table.
    function automatic void apply_timer_op(dtq_pkg::dtq_in_t op);
        dtq_pkg::dtq_out_t batch [$];
        dtq_pkg::dtq_out_t res;
        logic [TW:0]       sum;
        logic [TW-1:0]     deadline;
        logic [IW-1:0]     best_age;
        logic [IW-1:0]     age;
        int                best;
        int                slot;
        bit                done;

        res = '0;
        if (op.kind == dtq_pkg::KIND_TICK)
        begin
            // Fire due timers, earliest deadline first, oldest first among ties.
            now_ms = op.time_value;
            done   = 1'b0;
            while (!done && batch.size() < dtq_pkg::MAX_RESULTS)
            begin
                best     = -1;
                best_age = '0;
                for (int i = 0; i < TQ_DEPTH; i++)
                begin
                    if (slot_used[i] && slot_due[i] <= op.time_value)
                    begin
                        age = id_counter - slot_tid[i];
                        if (best < 0 || slot_due[i] < slot_due[best] ||
                            (slot_due[i] == slot_due[best] && age > best_age))
                        begin
                            best     = i;
                            best_age = age;
                        end
                    end
                end
                if (best < 0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    slot_used[best] = 1'b0;
                    res.result_kind = dtq_pkg::RK_FIRED;
                    res.tmr_id      = slot_tid[best];
                    batch.push_back(res);
                end
            end
        end
        else if (op.kind == dtq_pkg::KIND_CANCEL)
        begin
            // Remove the lowest slot holding the id; id 0 is never handed out.
            slot = -1;
            for (int i = 0; i < TQ_DEPTH; i++)
            begin
                if (slot < 0 && slot_used[i] && slot_tid[i] == op.cancel_id)
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                res.result_kind = dtq_pkg::RK_NOT_FOUND;
                res.tmr_id      = '0;
            end
            else
            begin
                slot_used[slot] = 1'b0;
                res.result_kind = dtq_pkg::RK_CANCELLED;
                res.tmr_id      = op.cancel_id;
            end
            batch.push_back(res);
        end
        else
        begin
            // Absolute or relative create; a relative deadline saturates.
            if (op.kind == dtq_pkg::KIND_ABS)
            begin
                deadline = op.time_value;
            end
            else
            begin
                sum      = {1'b0, now_ms} + {1'b0, op.time_value};
                deadline = sum[TW] ? MAX_MS : sum[TW-1:0];
            end
            slot = -1;
            for (int i = 0; i < TQ_DEPTH; i++)
            begin
                if (slot < 0 && !slot_used[i])
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                res.result_kind = dtq_pkg::RK_FULL;
                res.tmr_id      = '0;
            end
            else
            begin
                slot_used[slot] = 1'b1;
                slot_due[slot]  = deadline;
                slot_tid[slot]  = id_counter;
                res.result_kind = dtq_pkg::RK_CREATED;
                res.tmr_id      = id_counter;
                id_counter      = id_counter + IW'(1);
                if (id_counter == '0)
                begin
                    id_counter = IW'(1);
                end
            end
            batch.push_back(res);
        end

        // Mark the final result of the transaction.
        if (batch.size() > 0)
        begin
            res         = batch.pop_back();
            res.is_last = 1'b1;
            batch.push_back(res);
        end
        foreach (batch[i])
        begin
            due_results.push_back(batch[i]);
        end
    endfunction

    function automatic logic [TW-1:0] wide_ms();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TW-1:0];
    endfunction

    task automatic queue_op(logic [1:0] kind, logic [TW-1:0] tv, logic [IW-1:0] cid);
        dtq_pkg::dtq_in_t op;
        op.kind       = kind;
        op.time_value = tv;
        op.cancel_id  = cid;
        timer_ops_q.push_back(op);
    endtask

    // Wait until every queued transaction is taken and every result has come back.
    task automatic wait_drained();
        while (timer_ops_q.size() != 0 || item_valid || due_results.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Fill the table past full with clustered deadlines, cancel one, then fire the rest.
    task automatic build_fill_phase();
        logic [TW-1:0] t;
        logic [IW-1:0] first_id;
        int            free;
        t        = now_ms;
        first_id = id_counter;
        free     = 0;
        for (int i = 0; i < TQ_DEPTH; i++)
        begin
            if (!slot_used[i])
            begin
                free++;
            end
        end
        for (int n = 0; n < free + 2; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                queue_op(dtq_pkg::KIND_ABS, t + $urandom_range(0, 3), $urandom);
            end
            else
            begin
                queue_op(dtq_pkg::KIND_REL, $urandom_range(0, 3), $urandom);
            end
        end
        if (free > 0)
        begin
            queue_op(dtq_pkg::KIND_CANCEL, wide_ms(), first_id + $urandom_range(0, free - 1));
        end
        queue_op(dtq_pkg::KIND_TICK, t + 1, $urandom);
        queue_op(dtq_pkg::KIND_TICK, t + 3, $urandom);
        random_ops += free + 4 + ((free > 0) ? 1 : 0);
    endtask

    // A mix of creates, cancels and ticks around the current time.
    task automatic build_mixed_phase();
        logic [TW-1:0] t;
        logic [IW-1:0] id_guess;
        int            roll;
        int            sub;
        t        = now_ms;
        id_guess = id_counter;
        for (int n = 0; n < 20; n++)
        begin
            roll = $urandom_range(0, 99);
            sub  = $urandom_range(0, 99);
            if (roll < 30)
            begin
                queue_op(dtq_pkg::KIND_ABS,
                         (sub < 10) ? wide_ms() : t + $urandom_range(0, 200), $urandom);
                id_guess++;
            end
            else if (roll < 55)
            begin
                if (sub < 8)
                begin
                    queue_op(dtq_pkg::KIND_REL, wide_ms(), $urandom);
                end
                else if (sub < 12)
                begin
                    queue_op(dtq_pkg::KIND_REL, MAX_MS - $urandom_range(0, 3), $urandom);
                end
                else
                begin
                    queue_op(dtq_pkg::KIND_REL, $urandom_range(0, 200), $urandom);
                end
                id_guess++;
            end
            else if (roll < 75)
            begin
                if (sub < 10)
                begin
                    queue_op(dtq_pkg::KIND_CANCEL, wide_ms(), $urandom);
                end
                else if (sub < 14)
                begin
                    queue_op(dtq_pkg::KIND_CANCEL, wide_ms(), '0);
                end
                else
                begin
                    queue_op(dtq_pkg::KIND_CANCEL, wide_ms(), id_guess - $urandom_range(1, 20));
                end
            end
            else
            begin
                if (sub < 5)
                begin
                    t = t - $urandom_range(0, 50);
                end
                else if (sub < 9)
                begin
                    t = wide_ms();
                end
                else
                begin
                    t = t + $urandom_range(0, 150);
                end
                queue_op(dtq_pkg::KIND_TICK, t, $urandom);
            end
        end
        random_ops += 20;
    endtask

    // Driver: presents the next transaction after a random gap and holds it while stalled.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && taken_cnt != sent_cnt)
            begin
                item_valid <= 1'b1;
            end
            else if (gap_left != 0)
            begin
                item_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end
            else if (timer_ops_q.size() != 0)
            begin
                item       <= timer_ops_q.pop_front();
                item_valid <= 1'b1;
                sent_cnt   <= sent_cnt + 1;
                gap_left   <= tx_quiet ? 0 : $urandom_range(0, 16);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Each accepted input transaction updates the expected results.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            apply_timer_op(item);
            taken_cnt <= taken_cnt + 1;
        end
    end

    // Result stall: a fresh random hold-off for each result.
    always @(negedge clk)
    begin
        if (results_seen != results_paced)
        begin
            results_paced = results_seen;
            stall_left    = rx_quiet ? 0 : $urandom_range(0, 16);
        end
        result_stall <= (stall_left != 0);
        if (stall_left != 0 && result_valid)
        begin
            stall_left = stall_left - 1;
        end
    end

    // Monitor: compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen <= results_seen + 1;
            if (due_results.size() == 0)
            begin
                $error("unexpected result: result_kind %0d, tmr_id %0d, is_last %0d",
                       result.result_kind, result.tmr_id, result.is_last);
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.result_kind, result.result_kind);
                    error_count++;
                end
                if (result.tmr_id !== want.tmr_id)
                begin
                    $error("tmr_id: expected %0d, actual %0d", want.tmr_id, result.tmr_id);
                    error_count++;
                end
                if (result.is_last !== want.is_last)
                begin
                    $error("is_last: expected %0d, actual %0d", want.is_last, result.is_last);
                    error_count++;
                end
                case (want.result_kind)
                    dtq_pkg::RK_FIRED:     fired_seen++;
                    dtq_pkg::RK_FULL:      full_seen++;
                    dtq_pkg::RK_CANCELLED: cancel_hits++;
                    dtq_pkg::RK_NOT_FOUND: miss_seen++;
                    default:               ;
                endcase
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sequencer: reset, directed cases, then random phases separated by full drains.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty table: a tick with nothing due, cancel of id 0 and of the all-ones id.
        queue_op(dtq_pkg::KIND_TICK, '0, '0);
        queue_op(dtq_pkg::KIND_CANCEL, '0, '0);
        queue_op(dtq_pkg::KIND_CANCEL, MAX_MS, {IW{1'b1}});
        // Equal deadlines, an earlier one, a past deadline and the largest deadline.
        queue_op(dtq_pkg::KIND_ABS, 48'd100, '0);
        queue_op(dtq_pkg::KIND_ABS, 48'd100, '0);
        queue_op(dtq_pkg::KIND_ABS, 48'd50, '0);
        queue_op(dtq_pkg::KIND_REL, '0, '0);
        queue_op(dtq_pkg::KIND_ABS, MAX_MS, '0);
        // Cancel a pending timer, then the same id again.
        queue_op(dtq_pkg::KIND_CANCEL, '0, 32'd2);
        queue_op(dtq_pkg::KIND_CANCEL, '0, 32'd2);
        queue_op(dtq_pkg::KIND_TICK, 48'd100, '0);
        // Late time, saturating relative deadline, then time running backwards.
        queue_op(dtq_pkg::KIND_TICK, MAX_MS - 48'd15, '0);
        queue_op(dtq_pkg::KIND_REL, MAX_MS, '0);
        queue_op(dtq_pkg::KIND_TICK, 48'd5, '0);
        queue_op(dtq_pkg::KIND_REL, 48'd10, '0);
        queue_op(dtq_pkg::KIND_TICK, MAX_MS, '0);
        // Alternating bit patterns on both wide fields.
        queue_op(dtq_pkg::KIND_ABS, 48'h5555_5555_5555, 32'hAAAA_AAAA);
        queue_op(dtq_pkg::KIND_CANCEL, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
        queue_op(dtq_pkg::KIND_CANCEL, 48'h5555_5555_5555, 32'd8);
        wait_drained();

        // Random phases; the sender pauses after each one until all results are back.
        while (random_ops < RANDOM_OPS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (random_ops == 0 || $urandom_range(0, 3) == 0)
            begin
                build_fill_phase();
            end
            else
            begin
                build_mixed_phase();
            end
            wait_drained();
        end

        // Let any late result show up before the verdict.
        repeat (64) @(posedge clk);
        $display("Ran %0d transactions (%0d random) giving %0d results in %0d cycles",
                 taken_cnt, random_ops, results_seen, cycle_count);
        $display("Seen: %0d fired, %0d cancelled, %0d id misses, %0d table-full",
                 fired_seen, cancel_hits, miss_seen, full_seen);
        if (error_count == 0 && due_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dtq_pkg.sv
hdl/dtq_controller.sv
hdl/dtq_datapath.sv
hdl/deadline_timer_queue.sv
verif/tb_top.sv
